/* sv/triangle_face_normal_unit_macros.svh */
// Assertion macros for the triangle face normal checker.
`ifndef TRIANGLE_FACE_NORMAL_UNIT_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define TFN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tfn_pkg.sv */
// Shared constants for the triangle face normal unit.
package tfn_pkg;

  localparam int unsigned CoordBitsDef  = 24;
  localparam int unsigned NormalBitsDef = 16;
  localparam int unsigned QueueDepth    = 4;

  localparam logic [1:0] BeatA = 2'd0;
  localparam logic [1:0] BeatB = 2'd1;
  localparam logic [1:0] BeatC = 2'd2;

endpackage

/* sv/tfn_fifo.sv */
// Small queue between the cross-product front end and the normalizing back end.
module tfn_fifo
  import tfn_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 pop_i,
  output logic [WIDTH-1:0]                     rdata_o,
  output logic                                 empty_o,
  output logic [$clog2(QueueDepth+1)-1:0]      count_o
);

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth+1);

  logic [WIDTH-1:0] mem_q [QueueDepth];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? wptr_q + AW'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + AW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

/* sv/tfn_front.sv */
// Front end: edge vectors, cross product and degenerate-triangle filter.
module tfn_front
  import tfn_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       take_i,
  input  logic signed [COORD_BITS-1:0]               ax_i,
  input  logic signed [COORD_BITS-1:0]               ay_i,
  input  logic signed [COORD_BITS-1:0]               az_i,
  input  logic signed [COORD_BITS-1:0]               bx_i,
  input  logic signed [COORD_BITS-1:0]               by_i,
  input  logic signed [COORD_BITS-1:0]               bz_i,
  input  logic signed [COORD_BITS-1:0]               cx_i,
  input  logic signed [COORD_BITS-1:0]               cy_i,
  input  logic signed [COORD_BITS-1:0]               cz_i,
  output logic                                       push_o,
  output logic [9*COORD_BITS+3+3*(2*COORD_BITS+2)-1:0] push_data_o,
  output logic [1:0]                                 inflight_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned VW = 9 * COORD_BITS;

  logic               v1_q, v2_q, v3_q;
  logic [VW-1:0]      vert1_q, vert2_q, vert3_q;
  logic signed [DW-1:0] d_q  [6];
  logic signed [PW-1:0] pr_q [6];
  logic [PW:0]        df   [3];
  logic [PW:0]        ab   [3];
  logic [PW-1:0]      mag_d [3];
  logic [2:0]         neg_d;
  logic [PW-1:0]      mag3_q [3];
  logic [2:0]         neg3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= take_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vert1_q <= {cz_i, cy_i, cx_i, bz_i, by_i, bx_i, az_i, ay_i, ax_i};
    d_q[0]  <= $signed({bx_i[COORD_BITS-1], bx_i}) - $signed({ax_i[COORD_BITS-1], ax_i});
    d_q[1]  <= $signed({by_i[COORD_BITS-1], by_i}) - $signed({ay_i[COORD_BITS-1], ay_i});
    d_q[2]  <= $signed({bz_i[COORD_BITS-1], bz_i}) - $signed({az_i[COORD_BITS-1], az_i});
    d_q[3]  <= $signed({cx_i[COORD_BITS-1], cx_i}) - $signed({ax_i[COORD_BITS-1], ax_i});
    d_q[4]  <= $signed({cy_i[COORD_BITS-1], cy_i}) - $signed({ay_i[COORD_BITS-1], ay_i});
    d_q[5]  <= $signed({cz_i[COORD_BITS-1], cz_i}) - $signed({az_i[COORD_BITS-1], az_i});
    vert2_q <= vert1_q;
    pr_q[0] <= d_q[1] * d_q[5];
    pr_q[1] <= d_q[2] * d_q[4];
    pr_q[2] <= d_q[2] * d_q[3];
    pr_q[3] <= d_q[0] * d_q[5];
    pr_q[4] <= d_q[0] * d_q[4];
    pr_q[5] <= d_q[1] * d_q[3];
    vert3_q <= vert2_q;
    mag3_q  <= mag_d;
    neg3_q  <= neg_d;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      df[k]    = {pr_q[2*k][PW-1], pr_q[2*k]} - {pr_q[2*k+1][PW-1], pr_q[2*k+1]};
      neg_d[k] = df[k][PW];
      ab[k]    = neg_d[k] ? (~df[k] + (PW+1)'(1)) : df[k];
      mag_d[k] = ab[k][PW-1:0];
    end
  end

  assign push_o      = v3_q && ((|mag3_q[0]) || (|mag3_q[1]) || (|mag3_q[2]));
  assign push_data_o = {vert3_q, neg3_q, mag3_q[2], mag3_q[1], mag3_q[0]};
  assign inflight_o  = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);

endmodule

/* sv/tfn_back.sv */
// Back end: squared length by partial products, then bit-serial unit scaling.
module tfn_back
  import tfn_pkg::*;
#(
  parameter int unsigned COORD_BITS  = CoordBitsDef,
  parameter int unsigned NORMAL_BITS = NormalBitsDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         empty_i,
  input  logic [9*COORD_BITS+3+3*(2*COORD_BITS+2)-1:0] rdata_i,
  output logic                                         pop_o,
  input  logic                                         free_i,
  output logic                                         hand_o,
  output logic [9*COORD_BITS-1:0]                      hand_vert_o,
  output logic [3*NORMAL_BITS-1:0]                     hand_norm_o
);

  localparam int unsigned NW  = 2 * COORD_BITS + 2;
  localparam int unsigned HW  = NW / 2;
  localparam int unsigned SQW = 2 * NW;
  localparam int unsigned L2W = SQW + 2;
  localparam int unsigned F   = NORMAL_BITS - 1;
  localparam int unsigned TW  = SQW + 2 * F;
  localparam int unsigned XW  = TW + 5;
  localparam int unsigned VW  = 9 * COORD_BITS;
  localparam int unsigned BW  = $clog2(NORMAL_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SQR  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_HAND = 2'd3;

  localparam logic [1:0] PartLL = 2'd0;
  localparam logic [1:0] PartHL = 2'd1;
  localparam logic [1:0] PartHH = 2'd2;

  localparam logic [3:0] SqOps  = 4'd9;
  localparam logic [3:0] SqDone = 4'd10;

  logic [1:0]      state_q, state_d;
  logic [3:0]      st_q;
  logic [1:0]      k_q, part_q;
  logic [BW-1:0]   bcnt_q;
  logic            pv_q;
  logic [1:0]      pk_q, pp_q;
  logic [NW-1:0]   prod_q;

  logic [VW-1:0]   vert_q;
  logic [2:0]      neg_q;
  logic [NW-1:0]   mag_q [3];
  logic [SQW-1:0]  sq_q  [3];
  logic [L2W-1:0]  len2_q;
  logic [XW-1:0]   ls_q;
  logic [XW-1:0]   t_q   [3];
  logic [XW-1:0]   p_q   [3];
  logic [F:0]      qv_q  [3];

  logic [NW-1:0]   cur_mag;
  logic [HW-1:0]   op_a, op_b;
  logic [NW-1:0]   prod_d;
  logic [SQW-1:0]  acc_x;
  logic            issue;
  logic [XW:0]     dd   [3];
  logic            take [3];
  logic [NORMAL_BITS-1:0] qs [3];
  logic [NORMAL_BITS-1:0] nv [3];

  assign issue = (state_q == S_SQR) && (st_q < SqOps);
  assign pop_o = (state_q == S_IDLE) && !empty_i;
  assign hand_o = (state_q == S_HAND) && free_i;

  always_comb begin
    cur_mag = mag_q[k_q];
    op_a    = cur_mag[NW-1:HW];
    op_b    = cur_mag[HW-1:0];
    case (part_q)
      PartLL: op_a = cur_mag[HW-1:0];
      PartHL: op_a = cur_mag[NW-1:HW];
      PartHH: op_b = cur_mag[NW-1:HW];
      default: op_a = cur_mag[NW-1:HW];
    endcase
    prod_d = NW'(op_a) * NW'(op_b);
    case (pp_q)
      PartLL:  acc_x = SQW'(prod_q);
      PartHL:  acc_x = SQW'(prod_q) << (HW + 1);
      PartHH:  acc_x = SQW'(prod_q) << (2 * HW);
      default: acc_x = '0;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd[k]   = {1'b0, p_q[k]} + {1'b0, ls_q};
      take[k] = (dd[k] <= {1'b0, t_q[k]});
      qs[k]   = qv_q[k][F] ? {1'b0, {F{1'b1}}} : {1'b0, qv_q[k][F-1:0]};
      nv[k]   = neg_q[k] ? (~qs[k] + NORMAL_BITS'(1)) : qs[k];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (!empty_i) state_d = S_SQR;
      S_SQR:  if (st_q == SqDone) state_d = S_DIV;
      S_DIV:  if (bcnt_q == '0) state_d = S_HAND;
      S_HAND: if (free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= '0;
      k_q     <= '0;
      part_q  <= PartLL;
      bcnt_q  <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= issue;
      if (pop_o) begin
        st_q   <= '0;
        k_q    <= '0;
        part_q <= PartLL;
      end else if (state_q == S_SQR) begin
        st_q <= st_q + 4'd1;
        if (issue) begin
          if (part_q == PartHH) begin
            part_q <= PartLL;
            k_q    <= k_q + 2'd1;
          end else begin
            part_q <= part_q + 2'd1;
          end
        end
        if (st_q == SqDone) begin
          bcnt_q <= BW'(F);
        end
      end else if (state_q == S_DIV) begin
        bcnt_q <= bcnt_q - BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= rdata_i[k*NW +: NW];
        sq_q[k]  <= '0;
      end
      neg_q  <= rdata_i[3*NW +: 3];
      vert_q <= rdata_i[3*NW+3 +: VW];
      len2_q <= '0;
    end
    prod_q <= prod_d;
    pk_q   <= k_q;
    pp_q   <= part_q;
    if (pv_q) begin
      sq_q[pk_q] <= sq_q[pk_q] + acc_x;
      len2_q     <= len2_q + L2W'(acc_x);
    end
    if ((state_q == S_SQR) && (st_q == SqDone)) begin
      ls_q <= XW'(len2_q) << (2 * F);
      for (int k = 0; k < 3; k++) begin
        t_q[k]  <= XW'(sq_q[k]) << (2 * F);
        p_q[k]  <= '0;
        qv_q[k] <= '0;
      end
    end else if (state_q == S_DIV) begin
      ls_q <= ls_q >> 2;
      for (int k = 0; k < 3; k++) begin
        if (take[k]) begin
          t_q[k]  <= t_q[k] - dd[k][XW-1:0];
          p_q[k]  <= (p_q[k] >> 1) + ls_q;
          qv_q[k] <= {qv_q[k][F-1:0], 1'b1};
        end else begin
          p_q[k]  <= p_q[k] >> 1;
          qv_q[k] <= {qv_q[k][F-1:0], 1'b0};
        end
      end
    end
  end

  assign hand_vert_o = vert_q;
  assign hand_norm_o = {nv[2], nv[1], nv[0]};

endmodule

/* sv/tfn_emit.sv */
// Result stage: sends the three vertex beats of one triangle.
module tfn_emit
  import tfn_pkg::*;
#(
  parameter int unsigned COORD_BITS  = CoordBitsDef,
  parameter int unsigned NORMAL_BITS = NormalBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          hand_i,
  input  logic [9*COORD_BITS-1:0]       vert_i,
  input  logic [3*NORMAL_BITS-1:0]      norm_i,
  output logic                          free_o,
  output logic                          valid_o,
  output logic signed [COORD_BITS-1:0]  vertex_x_o,
  output logic signed [COORD_BITS-1:0]  vertex_y_o,
  output logic signed [COORD_BITS-1:0]  vertex_z_o,
  output logic signed [NORMAL_BITS-1:0] normal_x_o,
  output logic signed [NORMAL_BITS-1:0] normal_y_o,
  output logic signed [NORMAL_BITS-1:0] normal_z_o,
  output logic                          last_o
);

  localparam int unsigned CB = COORD_BITS;

  logic                       act_q;
  logic [1:0]                 beat_q;
  logic [9*CB-1:0]            vert_q;
  logic [3*NORMAL_BITS-1:0]   norm_q;
  logic [3*CB-1:0]            sel;

  assign free_o = !act_q || (beat_q == BeatC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      beat_q <= BeatA;
    end else if (hand_i) begin
      act_q  <= 1'b1;
      beat_q <= BeatA;
    end else if (act_q) begin
      if (beat_q == BeatC) begin
        act_q <= 1'b0;
      end else begin
        beat_q <= beat_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hand_i) begin
      vert_q <= vert_i;
      norm_q <= norm_i;
    end
  end

  always_comb begin
    case (beat_q)
      BeatA:   sel = vert_q[0 +: 3*CB];
      BeatB:   sel = vert_q[3*CB +: 3*CB];
      BeatC:   sel = vert_q[6*CB +: 3*CB];
      default: sel = vert_q[0 +: 3*CB];
    endcase
  end

  assign valid_o    = act_q;
  assign last_o     = act_q && (beat_q == BeatC);
  assign vertex_x_o = sel[0 +: CB];
  assign vertex_y_o = sel[CB +: CB];
  assign vertex_z_o = sel[2*CB +: CB];
  assign normal_x_o = norm_q[0 +: NORMAL_BITS];
  assign normal_y_o = norm_q[NORMAL_BITS +: NORMAL_BITS];
  assign normal_z_o = norm_q[2*NORMAL_BITS +: NORMAL_BITS];

endmodule

/* sv/triangle_face_normal_unit.sv */
// Top level of the triangle face normal unit.
// One triangle per start beat. Each non-degenerate triangle gives three result beats
// on consecutive cycles (vertices a, b, c, last_vertex_o high on c). Each beat carries
// the Q1.(NORMAL_BITS-1) unit normal truncated toward zero. The receiver cannot stall:
// every beat is valid for exactly one cycle. Degenerate triangles (zero cross product)
// give no beats. The front end is three stages. The back end pops the queue, squares
// the components on one shared multiplier, runs a bit-serial scaling loop over the
// normal bits and hands off to the result stage once it is free. A four-deep queue
// sits between the two. Start is taken every cycle until the front end and the queue
// together hold four triangles; busy then holds new triangles off. After that the
// sustained rate is one triangle per back-end pass.
module triangle_face_normal_unit
  import tfn_pkg::*;
#(
  parameter int unsigned COORD_BITS  = CoordBitsDef,
  parameter int unsigned NORMAL_BITS = NormalBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  ax_i,
  input  logic signed [COORD_BITS-1:0]  ay_i,
  input  logic signed [COORD_BITS-1:0]  az_i,
  input  logic signed [COORD_BITS-1:0]  bx_i,
  input  logic signed [COORD_BITS-1:0]  by_i,
  input  logic signed [COORD_BITS-1:0]  bz_i,
  input  logic signed [COORD_BITS-1:0]  cx_i,
  input  logic signed [COORD_BITS-1:0]  cy_i,
  input  logic signed [COORD_BITS-1:0]  cz_i,
  output logic                          result_valid_o,
  output logic signed [COORD_BITS-1:0]  vertex_x_o,
  output logic signed [COORD_BITS-1:0]  vertex_y_o,
  output logic signed [COORD_BITS-1:0]  vertex_z_o,
  output logic signed [NORMAL_BITS-1:0] normal_x_o,
  output logic signed [NORMAL_BITS-1:0] normal_y_o,
  output logic signed [NORMAL_BITS-1:0] normal_z_o,
  output logic                          last_vertex_o
);

  localparam int unsigned QW = 9 * COORD_BITS + 3 + 3 * (2 * COORD_BITS + 2);
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  logic                          take;
  logic                          push;
  logic [QW-1:0]                 push_data;
  logic [1:0]                    inflight;
  logic                          pop, empty;
  logic [QW-1:0]                 rdata;
  logic [CW-1:0]                 qcnt;
  logic [CW:0]                   occ;
  logic                          hand, free;
  logic [9*COORD_BITS-1:0]       hand_vert;
  logic [3*NORMAL_BITS-1:0]      hand_norm;

  assign occ  = {1'b0, qcnt} + (CW+1)'(inflight);
  assign busy = (occ >= (CW+1)'(QueueDepth));
  assign take = start && !busy;

  tfn_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni,
    .take_i(take),
    .ax_i, .ay_i, .az_i, .bx_i, .by_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .push_o(push), .push_data_o(push_data), .inflight_o(inflight)
  );

  tfn_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .wdata_i(push_data),
    .pop_i(pop), .rdata_o(rdata), .empty_o(empty), .count_o(qcnt)
  );

  tfn_back #(.COORD_BITS(COORD_BITS), .NORMAL_BITS(NORMAL_BITS)) u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .rdata_i(rdata), .pop_o(pop),
    .free_i(free), .hand_o(hand), .hand_vert_o(hand_vert), .hand_norm_o(hand_norm)
  );

  tfn_emit #(.COORD_BITS(COORD_BITS), .NORMAL_BITS(NORMAL_BITS)) u_emit (
    .clk_i, .rst_ni,
    .hand_i(hand), .vert_i(hand_vert), .norm_i(hand_norm),
    .free_o(free), .valid_o(result_valid_o),
    .vertex_x_o, .vertex_y_o, .vertex_z_o,
    .normal_x_o, .normal_y_o, .normal_z_o,
    .last_o(last_vertex_o)
  );

endmodule

/* sv/tfn_checker.sv */
// Port-level checker for the triangle face normal unit, bound to the top level.
`include "triangle_face_normal_unit_macros.svh"

module tfn_checker
  import tfn_pkg::*;
#(
  parameter int unsigned NORMAL_BITS = NormalBitsDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          result_valid_o,
  input logic                          last_vertex_o,
  input logic signed [NORMAL_BITS-1:0] normal_x_o,
  input logic signed [NORMAL_BITS-1:0] normal_y_o,
  input logic signed [NORMAL_BITS-1:0] normal_z_o
);

  localparam logic [NORMAL_BITS-1:0] NormMin = {1'b1, {(NORMAL_BITS-1){1'b0}}};

  `TFN_ASSERT_NEXT(a_run_continues, result_valid_o && !last_vertex_o, result_valid_o, "beat run broke before last vertex")
  `TFN_ASSERT_NEXT(a_normal_held, result_valid_o && !last_vertex_o, $stable(normal_x_o) && $stable(normal_y_o) && $stable(normal_z_o), "normal changed inside a triangle")
  `TFN_ASSERT_SAME(a_last_third, last_vertex_o, result_valid_o && $past(result_valid_o) && $past(result_valid_o, 2) && !$past(last_vertex_o), "last vertex not the third beat")
  `TFN_ASSERT_SAME(a_normal_range, result_valid_o, (normal_x_o != NormMin) && (normal_y_o != NormMin) && (normal_z_o != NormMin), "normal outside saturation range")

endmodule

bind triangle_face_normal_unit tfn_checker #(.NORMAL_BITS(NORMAL_BITS)) u_tfn_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .result_valid_o(result_valid_o),
  .last_vertex_o(last_vertex_o),
  .normal_x_o(normal_x_o),
  .normal_y_o(normal_y_o),
  .normal_z_o(normal_z_o)
);
